@@ rtl/mik_pkg.sv @@
// Shared constants and types for the mecanum inverse kinematics core.
package mik_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int NUM_WHEELS = 4;
    localparam int DIV_STEPS  = 32;
    localparam int VEL_W      = 48;
    localparam int PROD_W     = 52;

    localparam logic [19:0] RPM_GAIN = 20'd625762;
    localparam logic [15:0] MAG_MAX  = 16'hFFFF;

    localparam logic [29:0] HALF_LENGTH_RST  = 30'd19005;
    localparam logic [29:0] HALF_WIDTH_RST   = 30'd2556;
    localparam logic [30:0] WHEEL_RADIUS_RST = 31'd8192;

    typedef enum logic [1:0] {
        REG_HALF_LENGTH  = 2'd0,
        REG_HALF_WIDTH   = 2'd1,
        REG_WHEEL_RADIUS = 2'd2
    } reg_idx_t;

    // wheel index order: front left, front right, rear left, rear right
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] dq;    // dividend bits shift out on top, quotient bits in below
        logic        neg;
        logic        ovf;
    } wheel_div_t;

    typedef wheel_div_t [NUM_WHEELS-1:0] div_bus_t;

endpackage

@@ rtl/mik_front.sv @@
// Front stages: yaw term multiply, wheel speed sums, divider setup.
module mik_front
    import mik_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [30:0]        k_sum,
    input  logic [30:0]        radius,
    input  logic               up_vld,
    output logic               up_rdy,
    input  logic signed [31:0] vx,
    input  logic signed [31:0] vy,
    input  logic signed [31:0] om,
    output logic               dn_vld,
    input  logic               dn_rdy,
    output div_bus_t           dn_bus
);

    logic s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic rdy1, rdy2, rdy3;

    logic signed [63:0]      prod_reg;
    logic signed [31:0]      vx1_reg, vy1_reg;
    logic signed [VEL_W-1:0] v_reg [NUM_WHEELS];
    div_bus_t                bus_reg;

    logic signed [63:0]      prod;
    logic signed [VEL_W-1:0] kk, vxe, vye;
    logic signed [VEL_W-1:0] v_next [NUM_WHEELS];
    div_bus_t                bus_next;

    assign rdy3   = !s3_vld_reg || dn_rdy;
    assign rdy2   = !s2_vld_reg || rdy3;
    assign rdy1   = !s1_vld_reg || rdy2;
    assign up_rdy = rdy1;
    assign dn_vld = s3_vld_reg;
    assign dn_bus = bus_reg;

    assign prod = $signed({33'b0, k_sum}) * 64'(om);
    assign kk   = prod_reg[63:FRAC_BITS];
    assign vxe  = VEL_W'(vx1_reg);
    assign vye  = VEL_W'(vy1_reg);

    always_comb
    begin
        v_next[0] = kk - vxe + vye;
        v_next[1] = vxe + vye + kk;
        v_next[2] = kk - vxe - vye;
        v_next[3] = vxe - vye + kk;
    end

    always_comb
    begin
        logic [VEL_W-1:0] av;
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            bus_next[w].neg = v_reg[w][VEL_W-1];
            av = v_reg[w][VEL_W-1] ? VEL_W'(-v_reg[w]) : VEL_W'(v_reg[w]);
            bus_next[w].ovf = av >= {1'b0, radius, 16'b0};
            bus_next[w].rem = av[47:16];
            bus_next[w].dq  = {av[15:0], 16'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_vld_reg <= up_vld;
            if (rdy2)
                s2_vld_reg <= s1_vld_reg;
            if (rdy3)
                s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && up_vld)
        begin
            prod_reg <= prod;
            vx1_reg  <= vx;
            vy1_reg  <= vy;
        end
        if (rdy2 && s1_vld_reg)
            v_reg <= v_next;
        if (rdy3 && s2_vld_reg)
            bus_reg <= bus_next;
    end

endmodule

@@ rtl/mik_div_step.sv @@
// One restoring division step for all four wheels, registered.
module mik_div_step
    import mik_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [30:0] radius,
    input  logic        up_vld,
    output logic        up_rdy,
    input  div_bus_t    up_bus,
    output logic        dn_vld,
    input  logic        dn_rdy,
    output div_bus_t    dn_bus
);

    logic     vld_reg;
    div_bus_t bus_reg;
    div_bus_t bus_next;

    assign up_rdy = !vld_reg || dn_rdy;
    assign dn_vld = vld_reg;
    assign dn_bus = bus_reg;

    always_comb
    begin
        logic [32:0] t;
        logic [33:0] diff;
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            t    = {up_bus[w].rem, up_bus[w].dq[31]};
            diff = {1'b0, t} - {3'b0, radius};
            bus_next[w].neg = up_bus[w].neg;
            bus_next[w].ovf = up_bus[w].ovf;
            bus_next[w].rem = diff[33] ? t[31:0] : diff[31:0];
            bus_next[w].dq  = {up_bus[w].dq[30:0], !diff[33]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (up_rdy)
            vld_reg <= up_vld;
    end

    always_ff @(posedge clk)
    begin
        if (up_rdy && up_vld)
            bus_reg <= bus_next;
    end

endmodule

@@ rtl/mik_back.sv @@
// Back stages: RPM gain multiply, rounding, saturation and direction.
module mik_back
    import mik_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_vld,
    output logic        up_rdy,
    input  div_bus_t    up_bus,
    output logic        dn_vld,
    input  logic        dn_rdy,
    output logic [15:0] mag [NUM_WHEELS],
    output logic        fwd [NUM_WHEELS]
);

    logic              sa_vld_reg, sb_vld_reg;
    logic              rdya, rdyb;
    logic [PROD_W-1:0] p_reg   [NUM_WHEELS];
    logic              neg_reg [NUM_WHEELS];
    logic              ovf_reg [NUM_WHEELS];
    logic              nz_reg  [NUM_WHEELS];
    logic [15:0]       mag_reg [NUM_WHEELS];
    logic              fwd_reg [NUM_WHEELS];
    logic [PROD_W-1:0] p_next  [NUM_WHEELS];
    logic [15:0]       mag_next [NUM_WHEELS];

    assign rdyb   = !sb_vld_reg || dn_rdy;
    assign rdya   = !sa_vld_reg || rdyb;
    assign up_rdy = rdya;
    assign dn_vld = sb_vld_reg;
    assign mag    = mag_reg;
    assign fwd    = fwd_reg;

    always_comb
    begin
        logic [PROD_W:0] sum;
        logic [20:0]     q;
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            p_next[w] = {20'b0, up_bus[w].dq} * {32'b0, RPM_GAIN};
            sum  = {1'b0, p_reg[w]} + (neg_reg[w] ? 53'd65535 : 53'd0);
            q    = sum[52:32];
            if (ovf_reg[w] || (q[20:16] != 5'd0))
                mag_next[w] = MAG_MAX;
            else
                mag_next[w] = q[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_vld_reg <= 1'b0;
            sb_vld_reg <= 1'b0;
        end
        else
        begin
            if (rdya)
                sa_vld_reg <= up_vld;
            if (rdyb)
                sb_vld_reg <= sa_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            if (rdya && up_vld)
            begin
                p_reg[w]   <= p_next[w];
                neg_reg[w] <= up_bus[w].neg;
                ovf_reg[w] <= up_bus[w].ovf;
                nz_reg[w]  <= up_bus[w].ovf || (up_bus[w].dq != 32'd0);
            end
            if (rdyb && sa_vld_reg)
            begin
                mag_reg[w] <= mag_next[w];
                fwd_reg[w] <= !(neg_reg[w] && nz_reg[w]);
            end
        end
    end

endmodule

@@ rtl/mecanum_inverse_kinematics_core.sv @@
// Mecanum inverse kinematics core: config registers and pipeline top level.
//
// Input channel cmd (cmd_valid/cmd_stall) carries one body velocity item:
// vel_x, vel_y, yaw_rate in signed Q16.16. Output channel rpm
// (rpm_valid/rpm_stall) carries the four wheel RPM magnitudes and
// direction bits for that item, in the order items came in.
// The pipeline has 3 front stages (yaw multiply, wheel sums, divide
// setup), 32 one-bit divide stages, 2 back stages (gain multiply, round
// and saturate). Throughput is one item per cycle while rpm_stall is low.
// Every stage has its own valid bit and loads whenever it is empty or its
// successor moves, so a stalled output holds its item while bubbles in
// the pipeline still fill; cmd_stall rises only once the pipe is full
// behind a stalled output.
// Reset clears all valid bits and loads the default chassis registers.
// Registers (APB, byte address 4*i): half length, half width, wheel
// radius; a zero radius is used as one. Write them only while idle.
module mecanum_inverse_kinematics_core
    import mik_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] yaw_rate,
    output logic               rpm_valid,
    input  logic               rpm_stall,
    output logic [15:0]        front_left_rpm,
    output logic               front_left_fwd,
    output logic [15:0]        front_right_rpm,
    output logic               front_right_fwd,
    output logic [15:0]        rear_left_rpm,
    output logic               rear_left_fwd,
    output logic [15:0]        rear_right_rpm,
    output logic               rear_right_fwd
);

    logic [29:0] half_length_reg;
    logic [29:0] half_width_reg;
    logic [30:0] radius_reg;
    logic [30:0] radius_eff;
    logic [30:0] k_sum;
    logic        cmd_rdy;
    reg_idx_t    idx;

    logic     vld_chain [DIV_STEPS+1];
    logic     rdy_chain [DIV_STEPS+1];
    div_bus_t bus_chain [DIV_STEPS+1];

    logic [15:0] mag [NUM_WHEELS];
    logic        fwd [NUM_WHEELS];

    assign pready     = 1'b1;
    assign idx        = reg_idx_t'(paddr[3:2]);
    assign radius_eff = (radius_reg == 31'd0) ? 31'd1 : radius_reg;
    assign k_sum      = {1'b0, half_length_reg} + {1'b0, half_width_reg};
    assign cmd_stall  = !cmd_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_length_reg <= HALF_LENGTH_RST;
            half_width_reg  <= HALF_WIDTH_RST;
            radius_reg      <= WHEEL_RADIUS_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_HALF_LENGTH:  half_length_reg <= pwdata[29:0];
                REG_HALF_WIDTH:   half_width_reg  <= pwdata[29:0];
                REG_WHEEL_RADIUS: radius_reg      <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_HALF_LENGTH:  prdata = {2'b0, half_length_reg};
            REG_HALF_WIDTH:   prdata = {2'b0, half_width_reg};
            REG_WHEEL_RADIUS: prdata = {1'b0, radius_reg};
            default:          prdata = 32'd0;
        endcase
    end

    mik_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .k_sum  (k_sum),
        .radius (radius_eff),
        .up_vld (cmd_valid),
        .up_rdy (cmd_rdy),
        .vx     (vel_x),
        .vy     (vel_y),
        .om     (yaw_rate),
        .dn_vld (vld_chain[0]),
        .dn_rdy (rdy_chain[0]),
        .dn_bus (bus_chain[0])
    );

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_div
        mik_div_step u_step (
            .clk    (clk),
            .rst_n  (rst_n),
            .radius (radius_eff),
            .up_vld (vld_chain[s]),
            .up_rdy (rdy_chain[s]),
            .up_bus (bus_chain[s]),
            .dn_vld (vld_chain[s+1]),
            .dn_rdy (rdy_chain[s+1]),
            .dn_bus (bus_chain[s+1])
        );
    end

    mik_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .up_vld (vld_chain[DIV_STEPS]),
        .up_rdy (rdy_chain[DIV_STEPS]),
        .up_bus (bus_chain[DIV_STEPS]),
        .dn_vld (rpm_valid),
        .dn_rdy (!rpm_stall),
        .mag    (mag),
        .fwd    (fwd)
    );

    assign front_left_rpm  = mag[0];
    assign front_left_fwd  = fwd[0];
    assign front_right_rpm = mag[1];
    assign front_right_fwd = fwd[1];
    assign rear_left_rpm   = mag[2];
    assign rear_left_fwd   = fwd[2];
    assign rear_right_rpm  = mag[3];
    assign rear_right_fwd  = fwd[3];

`ifndef NO_ASSERTIONS
    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (rpm_valid && rpm_stall))
        else $error("input stalled while output not blocked");

    a_empty_out_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !rpm_valid |-> !cmd_stall)
        else $error("input stalled with empty output stage");

    a_radius_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        radius_eff != 31'd0)
        else $error("divisor is zero");
`endif

endmodule

@@ tb/sv/tb.sv @@
// Testbench for the mecanum inverse kinematics core: table-driven and random commands.
`timescale 1ns / 100ps

module tb;
    import mik_pkg::*;

    typedef struct packed {
        logic [15:0] fl_rpm;
        logic        fl_fwd;
        logic [15:0] fr_rpm;
        logic        fr_fwd;
        logic [15:0] rl_rpm;
        logic        rl_fwd;
        logic [15:0] rr_rpm;
        logic        rr_fwd;
    } wheels_t;

    typedef struct {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] om;
        logic               known;
        wheels_t            res;
    } cmd_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    logic signed [31:0] vel_x = '0, vel_y = '0, yaw_rate = '0;
    logic rpm_valid;
    logic rpm_stall = 1'b0;
    wheels_t got;

    logic [29:0] len_q16, wid_q16;
    logic [30:0] rad_q16;
    wheels_t wheel_queue[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit quiet = 1'b0;
    bit hold_long = 1'b0;
    bit sender_done = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    mecanum_inverse_kinematics_core dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
        .vel_x(vel_x), .vel_y(vel_y), .yaw_rate(yaw_rate),
        .rpm_valid(rpm_valid), .rpm_stall(rpm_stall),
        .front_left_rpm(got.fl_rpm), .front_left_fwd(got.fl_fwd),
        .front_right_rpm(got.fr_rpm), .front_right_fwd(got.fr_fwd),
        .rear_left_rpm(got.rl_rpm), .rear_left_fwd(got.rl_fwd),
        .rear_right_rpm(got.rr_rpm), .rear_right_fwd(got.rr_fwd)
    );

    function automatic logic [16:0] wheel_rpm(logic signed [63:0] v, logic [30:0] r);
        logic        neg;
        logic [63:0] av, wq, p, q;
        logic [16:0] o;
        neg = v < 0;
        av = neg ? 64'(-v) : 64'(v);
        wq = (av << 16) / 64'(r == 0 ? 31'd1 : r);
        o[0] = !(neg && wq != 0);
        if (wq >= 64'h1_0000_0000)
            o[16:1] = 16'hFFFF;
        else
        begin
            p = wq * 64'd625762;
            q = neg ? (p + 64'd65535) >> 16 : p >> 16;
            q = q >> 16;
            o[16:1] = q > 64'd65535 ? 16'hFFFF : q[15:0];
        end
        return o;
    endfunction

    function automatic wheels_t wheel_speeds(logic signed [31:0] vx, logic signed [31:0] vy,
                                             logic signed [31:0] om);
        logic signed [63:0] kk, k, x, y;
        wheels_t w;
        x = vx;
        y = vy;
        kk = $signed({34'd0, len_q16}) + $signed({34'd0, wid_q16});
        k = (kk * 64'(om)) >>> 16;
        {w.fl_rpm, w.fl_fwd} = wheel_rpm(k - x + y, rad_q16);
        {w.fr_rpm, w.fr_fwd} = wheel_rpm(x + y + k, rad_q16);
        {w.rl_rpm, w.rl_fwd} = wheel_rpm(k - x - y, rad_q16);
        {w.rr_rpm, w.rr_fwd} = wheel_rpm(x - y + k, rad_q16);
        return w;
    endfunction

    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 4'(idx) << 2; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_HALF_LENGTH:  len_q16 = val[29:0];
            REG_HALF_WIDTH:   wid_q16 = val[29:0];
            REG_WHEEL_RADIUS: rad_q16 = val[30:0];
            default: ;
        endcase
    endtask

    task automatic send_cmd(logic signed [31:0] vx, logic signed [31:0] vy,
                            logic signed [31:0] om, logic known, wheels_t res);
        int gap;
        wheels_t pred;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1; vel_x <= vx; vel_y <= vy; yaw_rate <= om;
        pred = wheel_speeds(vx, vy, om);
        if (known && pred != res)
            $display("table row disagrees with prediction for %h %h %h", vx, vy, om);
        do @(posedge clk); while (cmd_stall);
        wheel_queue.push_back(known ? res : pred);
    endtask

    task automatic drain;
        cmd_valid <= 1'b0;
        while (wheel_queue.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_vel();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $signed($urandom_range(0, 2 * 65536)) - 65536;
            2: return $signed($urandom_range(0, 40 * 65536)) - 20 * 65536;
            default: return $signed($urandom_range(0, 4096)) - 2048;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rpm_valid && !rpm_stall)
        begin
            if (wheel_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end
            else
            begin
                if (got !== wheel_queue[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", wheel_queue[0], got);
                end
                void'(wheel_queue.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rpm_valid && !rpm_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : receiver
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                rpm_stall <= 1'b1;
                n = 0;
                while (n < 120)
                begin
                    @(posedge clk);
                    n++;
                end
                rpm_stall <= 1'b0;
                hold_long = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                rpm_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                rpm_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        cmd_row_t rows[$];
        cmd_row_t r;
        wheels_t zero_res;
        wheels_t sat_res;
        len_q16 = HALF_LENGTH_RST;
        wid_q16 = HALF_WIDTH_RST;
        rad_q16 = WHEEL_RADIUS_RST;
        zero_res = '{16'd0, 1'b1, 16'd0, 1'b1, 16'd0, 1'b1, 16'd0, 1'b1};
        sat_res = '{16'd0, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0, 16'd0, 1'b1};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back('{32'sd0, 32'sd0, 32'sd0, 1'b1, zero_res});
        rows.push_back('{32'sh4000_0000, 32'sh4000_0000, 32'sd0, 1'b1, sat_res});
        rows.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, zero_res});
        rows.push_back('{-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, 1'b0, zero_res});
        rows.push_back('{32'sh7FFF_FFFF, -32'sh8000_0000, 32'sd0, 1'b0, zero_res});
        rows.push_back('{32'sd65536, 32'sd0, 32'sd0, 1'b0, zero_res});
        rows.push_back('{32'sd0, 32'sd65536, 32'sd0, 1'b0, zero_res});
        rows.push_back('{32'sd0, 32'sd0, 32'sd65536, 1'b0, zero_res});
        rows.push_back('{-32'sd1, 32'sd0, 32'sd0, 1'b0, zero_res});
        rows.push_back('{32'sd0, -32'sd1, -32'sd1, 1'b0, zero_res});
        rows.push_back('{-32'sd65536, 32'sd32768, -32'sd131072, 1'b0, zero_res});
        rows.push_back('{32'shFFFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, zero_res});
        foreach (rows[i])
        begin
            r = rows[i];
            send_cmd(r.vx, r.vy, r.om, r.known, r.res);
        end
        drain();

        // zero radius behaves as one; tiny chassis
        reg_write(REG_WHEEL_RADIUS, 32'd0);
        reg_write(REG_HALF_LENGTH, 32'd0);
        reg_write(REG_HALF_WIDTH, 32'd0);
        for (int i = 0; i < 8; i++) send_cmd(rand_vel(), rand_vel(), rand_vel(), 1'b0, zero_res);
        drain();
        reg_write(REG_WHEEL_RADIUS, 32'h7FFF_FFFF);
        reg_write(REG_HALF_LENGTH, 32'h3FFF_FFFF);
        reg_write(REG_HALF_WIDTH, 32'h3FFF_FFFF);
        for (int i = 0; i < 8; i++) send_cmd($urandom(), $urandom(), $urandom(), 1'b0, zero_res);
        send_cmd(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, zero_res);
        send_cmd(-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, 1'b0, zero_res);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            reg_write(REG_HALF_LENGTH, $urandom_range(0, 65536));
            reg_write(REG_HALF_WIDTH, $urandom_range(0, 65536));
            reg_write(REG_WHEEL_RADIUS, ph == 0 ? 32'd8192 : $urandom_range(1, 65536));
            if (ph == 2) hold_long = 1'b1;
            if (ph == 4) quiet = 1'b1;
            for (int i = 0; i < 100; i++)
                send_cmd(rand_vel(), rand_vel(), rand_vel(), 1'b0, zero_res);
            drain();
        end

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
